// ----- rtl/vgd_pkg.sv -----
// package for the voxel grid downsampler: default parameters, widths, states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vgd_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int PROBES_DEF      = 8;
    localparam int AXIS_BITS_DEF   = 21;
    localparam int COORD_W         = 32;
    localparam int COUNT_W         = 24;
    localparam int FOLD_W          = 20;
    localparam int ENTRY_W         = 64;
    localparam int KEY_SLOT_W      = 63;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_HASH,
        ST_MOD,
        ST_RD,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/vgd_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module vgd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/voxel_grid_downsample.sv -----
// voxel grid downsampler top level: quantizer, hash probe sequencer, result register
// depends on vgd_pkg and vgd_ram
`timescale 1ns / 1ps
`default_nettype none
// One point is taken per transfer and one result is returned for it, keeping the
// first visible point of each voxel. A point passes through the idle state that
// takes it, the shared 33x33 multiplier, the key fold, a reciprocal remainder when
// TABLE_DEPTH is not a power of two (none otherwise), a read and a compare per
// probe of the voxel table ram and the handover of the result; an invisible point
// goes from the multiplier state straight to the handover. After reset, and for
// each point flagged first_point before it is looked up, a clearing pass wipes
// the table; no point is taken during the pass after reset. The result register
// lets the next point enter while a result waits downstream. Writes to
// inverse_leaf are taken at any time but belong between clouds while the block is
// idle.
module voxel_grid_downsample
    import vgd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PROBES      = PROBES_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [95:0]  i_s_tdata,   // x_coord, y_coord, z_coord
    input  wire logic [1:0]   i_s_tuser,   // visible, first_point
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [23:0]       o_m_tdata,   // kept_count
    output logic [1:0]        o_m_tuser,   // keep, table_full
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int PW      = $clog2(PROBES) + 1;
    localparam int KW      = 3 * AXIS_BITS;
    localparam int XW      = (ADDR_W > FOLD_W) ? ADDR_W : FOLD_W;
    localparam bit IS_POW2 = (TABLE_DEPTH == (1 << ADDR_W));
    localparam int QW      = 33;
    localparam int RS      = FOLD_W + ADDR_W;
    localparam int RW      = FOLD_W + 1;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / 64'(TABLE_DEPTH));
    localparam logic signed [QW-1:0] IDX_HI = QW'((64'sd1 <<< (AXIS_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] IDX_LO = QW'(-(64'sd1 <<< (AXIS_BITS - 1)));

    t_state r_state, n_state;
    logic [COORD_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic r_vis, n_vis, r_pend, n_pend;
    logic [31:0] r_inv;
    logic signed [64:0] r_prod, n_prod;
    logic [2:0] r_step, n_step;
    logic [KW-1:0] r_key, n_key;
    logic [FOLD_W-1:0] r_fold, n_fold;
    logic [FOLD_W-1:0] r_qest, n_qest;
    logic [4:0] r_mcnt, n_mcnt;
    logic [ADDR_W-1:0] r_slot, n_slot, r_clr, n_clr;
    logic [PW-1:0] r_probe, n_probe;
    logic [COUNT_W-1:0] r_count, n_count;
    logic r_keep, n_keep, r_full, n_full;
    logic r_ovalid, n_ovalid;
    logic [COUNT_W-1:0] r_ocount, n_ocount;
    logic r_okeep, n_okeep, r_ofull, n_ofull;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [COORD_W-1:0] mul_coord;
    logic signed [QW-1:0] q_idx, q_sat;
    logic [AXIS_BITS-1:0] q_field;
    logic [ENTRY_W-1:0] key_ext;
    logic [FOLD_W-1:0] fold;
    logic [FOLD_W+RW-1:0] mod_prod;
    logic [FOLD_W-1:0] mod_diff;
    logic [XW-1:0] mod_ext, mod_red;
    logic [XW-1:0] fold_ext;
    logic [ADDR_W-1:0] slot_next;
    logic [COUNT_W-1:0] count_inc;

    vgd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_ocount;
    assign o_m_tuser   = {r_ofull, r_okeep};

    always_comb begin
        case (r_step)
            3'd0:    mul_coord = r_x;
            3'd1:    mul_coord = r_y;
            default: mul_coord = r_z;
        endcase
        q_idx = r_prod[64:32];
        if (q_idx > IDX_HI) begin
            q_sat = IDX_HI;
        end else if (q_idx < IDX_LO) begin
            q_sat = IDX_LO;
        end else begin
            q_sat = q_idx;
        end
        q_field  = q_sat[AXIS_BITS-1:0] ^ (AXIS_BITS'(1) << (AXIS_BITS - 1));
        key_ext  = ENTRY_W'(r_key);
        fold     = key_ext[19:0] ^ key_ext[39:20] ^ key_ext[59:40]
                 ^ FOLD_W'(key_ext[63:60]);
        fold_ext = XW'(fold);
        // quotient estimate is exact or one low, one subtract corrects it
        mod_prod = r_fold * RECIP;
        mod_diff = r_fold - FOLD_W'(r_qest * FOLD_W'(TABLE_DEPTH));
        mod_ext  = XW'(mod_diff);
        mod_red  = (mod_ext >= XW'(TABLE_DEPTH)) ? mod_ext - XW'(TABLE_DEPTH) : mod_ext;
        slot_next = (r_slot == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        count_inc = (r_count == {COUNT_W{1'b1}}) ? r_count : r_count + 1'b1;
    end

    always_comb begin
        n_state  = r_state;
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_vis    = r_vis;
        n_pend   = r_pend;
        n_prod   = r_prod;
        n_step   = r_step;
        n_key    = r_key;
        n_fold   = r_fold;
        n_qest   = r_qest;
        n_mcnt   = r_mcnt;
        n_slot   = r_slot;
        n_clr    = r_clr;
        n_probe  = r_probe;
        n_count  = r_count;
        n_keep   = r_keep;
        n_full   = r_full;
        n_ovalid = r_ovalid;
        n_ocount = r_ocount;
        n_okeep  = r_okeep;
        n_ofull  = r_ofull;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = {1'b1, KEY_SLOT_W'(r_key)};

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_clr   = '0;
                    n_pend  = 1'b0;
                    n_step  = '0;
                    n_state = r_pend ? ST_MUL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_x    = i_s_tdata[31:0];
                    n_y    = i_s_tdata[63:32];
                    n_z    = i_s_tdata[95:64];
                    n_vis  = i_s_tuser[0];
                    n_step = '0;
                    n_keep = 1'b0;
                    n_full = 1'b0;
                    if (i_s_tuser[1]) begin
                        n_count = '0;
                        n_pend  = 1'b1;
                        n_clr   = '0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (!r_vis) begin
                    n_state = ST_DONE;
                end else begin
                    if (r_step < 3'd3) begin
                        n_prod = $signed({mul_coord[COORD_W-1], mul_coord})
                               * $signed({1'b0, r_inv});
                    end
                    if (r_step != 3'd0) begin
                        n_key = KW'({r_key, q_field});
                    end
                    n_step = r_step + 1'b1;
                    if (r_step == 3'd3) begin
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                n_probe = '0;
                n_fold  = fold;
                n_mcnt  = '0;
                if (IS_POW2) begin
                    n_slot  = fold_ext[ADDR_W-1:0];
                    n_state = ST_RD;
                end else begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (r_mcnt == 5'd0) begin
                    n_qest = FOLD_W'(mod_prod >> RS);
                    n_mcnt = r_mcnt + 1'b1;
                end else begin
                    n_slot  = mod_red[ADDR_W-1:0];
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!ram_rdata[ENTRY_W-1]) begin
                    ram_we  = 1'b1;
                    n_keep  = 1'b1;
                    n_count = count_inc;
                    n_state = ST_DONE;
                end else if (ram_rdata[KEY_SLOT_W-1:0] == KEY_SLOT_W'(r_key)) begin
                    n_state = ST_DONE;
                end else if (r_probe == PW'(PROBES - 1)) begin
                    n_keep  = 1'b1;
                    n_full  = 1'b1;
                    n_count = count_inc;
                    n_state = ST_DONE;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_slot  = slot_next;
                    n_state = ST_RD;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ocount = r_count;
                    n_okeep  = r_keep;
                    n_ofull  = r_full;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_pend   <= 1'b0;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_inv    <= 32'd65536;
            r_step   <= '0;
            r_mcnt   <= '0;
            r_probe  <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_step   <= n_step;
            r_mcnt   <= n_mcnt;
            r_probe  <= n_probe;
            if (i_cfg_valid) begin
                r_inv <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_vis    <= n_vis;
        r_prod   <= n_prod;
        r_key    <= n_key;
        r_fold   <= n_fold;
        r_qest   <= n_qest;
        r_slot   <= n_slot;
        r_keep   <= n_keep;
        r_full   <= n_full;
        r_ocount <= n_ocount;
        r_okeep  <= n_okeep;
        r_ofull  <= n_ofull;
    end

endmodule
`default_nettype wire
